FILE: hdl/mefbq_pkg.sv
// ----------------------------------------------------------------------------
// MIDI event filter byte queue package
// Shared types and MIDI status codes for the event filter and its byte ring.
// ----------------------------------------------------------------------------
package mefbq_pkg;

   // transaction function codes
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // configuration register selects (byte address bit 2)
   localparam logic CSR_CLOCK_DIVIDE  = 1'b0;
   localparam logic CSR_CHANNEL_LIMIT = 1'b1;

   // reset values of the configuration registers
   localparam logic [3:0] DIVIDE_RESET = 4'd6;
   localparam logic [4:0] LIMIT_RESET  = 5'd4;

   // MIDI status codes
   localparam logic [7:0] ST_CHAN_FIRST   = 8'h80;
   localparam logic [7:0] ST_CHAN_LAST    = 8'hEF;
   localparam logic [3:0] KIND_PROGRAM    = 4'hC;
   localparam logic [3:0] KIND_PRESSURE   = 4'hD;
   localparam logic [7:0] ST_TIMING_CLOCK = 8'hF8;
   localparam logic [7:0] ST_START        = 8'hFA;
   localparam logic [7:0] ST_CONTINUE     = 8'hFB;
   localparam logic [7:0] ST_STOP         = 8'hFC;
   localparam logic [7:0] ST_SYS_RESET    = 8'hFF;

   // control of the single-port ring memory
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ring_ctl_type;

   // engine states, one-hot
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PUSH = 4'b0010,
      S_READ = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

endpackage

FILE: hdl/mefbq_ring.sv
// ----------------------------------------------------------------------------
// MIDI event filter byte ring
// Single-port byte memory: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module mefbq_ring #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                       clock,
   input  mefbq_pkg::ring_ctl_type    ctl,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] addr,
   input  logic [7:0]                 wr_data,
   output logic [7:0]                 rd_data
);
   import mefbq_pkg::*;

   logic [7:0] mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   // one access per cycle, read data registered
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end else if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/midi_event_filter_byte_queue.sv
// ----------------------------------------------------------------------------
// MIDI event filter byte queue
// Filters MIDI events into a byte ring and drains inverted bytes on request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: an event (status, data1, data2) to filter
//   and queue, or a drain request. Every transaction gives exactly one result
//   on rsp_*: out_valid/out_byte for a drain, recovered for an event.
//   Transactions are handled one at a time. An event writes 0 to 3 bytes
//   (an overflow recovery write included) one at a time: the ring memory
//   has a single port, one byte per cycle. A drain of a non-empty ring
//   goes through a registered memory read, a drain of an empty ring
//   straight to the result. The next transaction is accepted once the
//   engine has handed its result to the output register and is idle.
//   The output register lets the next transaction be accepted while a result
//   waits; if the receiver stalls, the engine holds its finished result and
//   accepts nothing more until the output register is free.
//   Reset empties the ring (both pointers to zero), clears the clock divider
//   count and loads clock_divide = 6 and channel_limit = 4. The ring contents
//   need no clearing pass. csr_* is an APB-style port: clock_divide at byte
//   address 0, channel_limit at byte address 4.
// ----------------------------------------------------------------------------
module midi_event_filter_byte_queue #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_status,
   input  logic [7:0]  req_data1,
   input  logic [7:0]  req_data2,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_recovered,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mefbq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);

   state_type    state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [3:0]   cc_ff, cc_in;
   logic [3:0]   div_ff;
   logic [4:0]   lim_ff;
   logic [7:0]   byte_ff [3];
   logic [7:0]   byte_in [3];
   logic [1:0]   cnt_ff, cnt_in, idx_ff, idx_in;
   logic         rec_ok_ff, rec_ok_in;
   logic         res_valid_ff, res_valid_in;
   logic [7:0]   res_byte_ff, res_byte_in;
   logic         res_rec_ff, res_rec_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_out_valid_ff;
   logic [7:0]   rsp_out_byte_ff;
   logic         rsp_recovered_ff;

   ring_ctl_type  ring_ctl;
   logic [AW-1:0] ring_addr;
   logic [7:0]    ring_wr_data, ring_rd_data;

   logic          req_take, out_free, out_load, csr_write;
   logic [AW-1:0] wp_step, rp_step;
   logic [3:0]    cc_inc;
   logic          chan_msg, full;

   // byte ring memory
   mefbq_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
      .clock   (clock),
      .ctl     (ring_ctl),
      .addr    (ring_addr),
      .wr_data (ring_wr_data),
      .rd_data (ring_rd_data)
   );

   // handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == S_DONE) && out_free;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // pointer arithmetic, wrapping at the ring depth
   assign wp_step  = (wp_ff == PTR_LAST) ? '0 : wp_ff + AW'(1);
   assign rp_step  = (rp_ff == PTR_LAST) ? '0 : rp_ff + AW'(1);
   assign full     = (wp_step == rp_ff);
   assign cc_inc   = cc_ff + 4'd1;
   assign chan_msg = (req_status >= ST_CHAN_FIRST) && (req_status <= ST_CHAN_LAST)
                     && ({1'b0, req_status[3:0]} < lim_ff);

   // engine next state
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cc_in        = cc_ff;
      byte_in      = byte_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rec_ok_in    = rec_ok_ff;
      res_valid_in = res_valid_ff;
      res_byte_in  = res_byte_ff;
      res_rec_in   = res_rec_ff;
      ring_ctl     = '0;
      ring_addr    = rp_ff;
      ring_wr_data = byte_ff[idx_ff];
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_valid_in = 1'b0;
               res_byte_in  = 8'h00;
               res_rec_in   = 1'b0;
               idx_in       = 2'd0;
               cnt_in       = 2'd0;
               rec_ok_in    = 1'b0;
               byte_in[0]   = req_status;
               byte_in[1]   = req_data1;
               byte_in[2]   = req_data2;
               if (req_func == FUNC_DRAIN) begin
                  // drain: start the read of the oldest byte
                  if (rp_ff != wp_ff) begin
                     ring_ctl.rd_en = 1'b1;
                     state_in       = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  // classify the event into a byte list
                  if (chan_msg) begin
                     rec_ok_in = 1'b1;
                     if (req_status[7:4] == KIND_PROGRAM
                         || req_status[7:4] == KIND_PRESSURE) begin
                        cnt_in = 2'd2;
                     end else begin
                        cnt_in = 2'd3;
                     end
                  end else if (req_status == ST_TIMING_CLOCK) begin
                     if (cc_inc >= div_ff) begin
                        cc_in  = 4'd0;
                        cnt_in = 2'd1;
                     end else begin
                        cc_in = cc_inc;
                     end
                  end else if (req_status == ST_START || req_status == ST_CONTINUE) begin
                     cc_in      = 4'd0;
                     cnt_in     = 2'd2;
                     rec_ok_in  = 1'b1;
                     byte_in[1] = ST_TIMING_CLOCK;
                  end else if (req_status == ST_STOP || req_status == ST_SYS_RESET) begin
                     cc_in  = 4'd0;
                     cnt_in = 2'd1;
                  end
                  state_in = (cnt_in != 2'd0) ? S_PUSH : S_DONE;
               end
            end
         end
         S_PUSH: begin
            ring_ctl.wr_en = 1'b1;
            if (full) begin
               if (rec_ok_ff) begin
                  // overflow recovery: empty the ring and queue a system reset
                  ring_addr    = '0;
                  ring_wr_data = ST_SYS_RESET;
                  wp_in        = AW'(1);
                  rp_in        = '0;
                  cc_in        = 4'd0;
                  res_rec_in   = 1'b1;
               end else begin
                  ring_ctl.wr_en = 1'b0;
               end
               state_in = S_DONE;
            end else begin
               ring_addr = wp_ff;
               wp_in     = wp_step;
               if (idx_ff == cnt_ff - 2'd1) begin
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         S_READ: begin
            res_valid_in = 1'b1;
            res_byte_in  = ~ring_rd_data;
            rp_in        = rp_step;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // engine registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         cc_ff    <= 4'd0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         cc_ff    <= cc_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      rec_ok_ff    <= rec_ok_in;
      res_valid_ff <= res_valid_in;
      res_byte_ff  <= res_byte_in;
      res_rec_ff   <= res_rec_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_out_valid_ff <= res_valid_ff;
         rsp_out_byte_ff  <= res_byte_ff;
         rsp_recovered_ff <= res_rec_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_recovered = rsp_recovered_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= DIVIDE_RESET;
         lim_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_CLOCK_DIVIDE:  div_ff <= csr_pwdata[3:0];
            CSR_CHANNEL_LIMIT: lim_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[2])
         CSR_CLOCK_DIVIDE:  csr_prdata = {28'd0, div_ff};
         CSR_CHANNEL_LIMIT: csr_prdata = {27'd0, lim_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   // the ring port never reads and writes at once
   a_ring_single_port: assert property (@(posedge clock) disable iff (reset)
      !(ring_ctl.wr_en && ring_ctl.rd_en))
      else $error("ring read and write in the same cycle");

   // a recovery leaves exactly the system reset byte in the ring
   a_recovery_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_rec_ff) |-> (wp_ff == AW'(1) && rp_ff == '0))
      else $error("recovery left the ring in a wrong state");

   // a memory read is always followed by its result
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_DONE && res_valid_ff))
      else $error("drain read did not complete");

   // the engine only starts on an accepted transaction
   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |=> (state_ff == S_IDLE))
      else $error("engine left idle without a transaction");

endmodule

FILE: verif/mefbq_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event filter byte queue scoreboard
// Keeps its own copy of the byte ring, divider count and registers, works out
// the result of every accepted request transaction and checks each response
// transaction against the oldest result still waiting.
// ----------------------------------------------------------------------------
package mefbq_check_pkg;
   import mefbq_pkg::*;

   localparam int RING_SLOTS = 256;

   // one response transaction
   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       recovered;
   } step_result_type;

   class ring_scoreboard;
      logic [7:0]      ring_bytes [RING_SLOTS];
      int unsigned     wr_idx;
      int unsigned     rd_idx;
      logic [3:0]      clock_count;
      logic [3:0]      clock_divide;
      logic [4:0]      channel_limit;
      step_result_type pending_results [$];
      int              errors;
      int              checked;

      function new();
         foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
         wr_idx        = 0;
         rd_idx        = 0;
         clock_count   = 4'd0;
         clock_divide  = DIVIDE_RESET;
         channel_limit = LIMIT_RESET;
         errors        = 0;
         checked       = 0;
      endfunction

      function void set_config(input logic [3:0] divide, input logic [4:0] limit);
         clock_divide  = divide;
         channel_limit = limit;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // ring keeps one slot empty, so a push onto a full ring is refused
      function bit push_byte(input logic [7:0] b);
         int unsigned nxt;
         nxt = (wr_idx + 1) % RING_SLOTS;
         if (nxt == rd_idx) return 1'b0;
         ring_bytes[wr_idx] = b;
         wr_idx = nxt;
         return 1'b1;
      endfunction

      // overflow recovery: empty the ring and queue a system reset
      function void recover_ring();
         wr_idx      = 0;
         rd_idx      = 0;
         clock_count = 4'd0;
         void'(push_byte(ST_SYS_RESET));
      endfunction

      // filter one event into the ring, returns the recovery flag
      function logic filter_event(input logic [7:0] st, input logic [7:0] d1,
                                  input logic [7:0] d2);
         bit ok;
         ok = 1'b1;
         if (st >= ST_CHAN_FIRST && st <= ST_CHAN_LAST) begin
            if ({1'b0, st[3:0]} < channel_limit) begin
               ok = push_byte(st);
               if (ok) ok = push_byte(d1);
               if (ok && st[7:4] != KIND_PROGRAM && st[7:4] != KIND_PRESSURE)
                  ok = push_byte(d2);
            end
         end else if (st == ST_TIMING_CLOCK) begin
            clock_count = clock_count + 4'd1;
            if (clock_count >= clock_divide) begin
               clock_count = 4'd0;
               void'(push_byte(st));
            end
         end else if (st == ST_START || st == ST_CONTINUE) begin
            clock_count = 4'd0;
            ok = push_byte(st);
            if (ok) ok = push_byte(ST_TIMING_CLOCK);
         end else if (st == ST_STOP || st == ST_SYS_RESET) begin
            clock_count = 4'd0;
            void'(push_byte(st));
         end
         if (!ok) recover_ring();
         return !ok;
      endfunction

      // accepted request transaction: predict its response
      function void note_request(input logic func, input logic [7:0] st,
                                 input logic [7:0] d1, input logic [7:0] d2);
         step_result_type r;
         r.out_valid = 1'b0;
         r.out_byte  = 8'h00;
         r.recovered = 1'b0;
         if (func == FUNC_DRAIN) begin
            if (rd_idx != wr_idx) begin
               r.out_valid = 1'b1;
               r.out_byte  = ~ring_bytes[rd_idx];
               rd_idx      = (rd_idx + 1) % RING_SLOTS;
            end
         end else begin
            r.recovered = filter_event(st, d1, d2);
         end
         pending_results.push_back(r);
      endfunction

      task report_mismatch(input string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      // accepted response transaction: compare with the oldest prediction
      task check_response(input logic v, input logic [7:0] b, input logic rec);
         step_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response %0d with nothing outstanding", checked));
            return;
         end
         want = pending_results.pop_front();
         if (v !== want.out_valid)
            report_mismatch($sformatf("response %0d out_valid %b, want %b",
                                      checked, v, want.out_valid));
         if (b !== want.out_byte)
            report_mismatch($sformatf("response %0d out_byte %h, want %h",
                                      checked, b, want.out_byte));
         if (rec !== want.recovered)
            report_mismatch($sformatf("response %0d recovered %b, want %b",
                                      checked, rec, want.recovered));
         checked++;
      endtask
   endclass

endpackage

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event filter byte queue testbench
// Drives event and drain transactions with bursty traffic and a stalling
// receiver, sweeps the divider and channel limit registers over the APB-style
// port and checks every response against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;
   import mefbq_pkg::*;
   import mefbq_check_pkg::*;

   localparam int RANDOM_ITEMS    = 1600;
   localparam int PHASES          = 8;
   localparam int RESET_CYCLES    = 7;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 16;
   localparam int LIMIT_NS        = 2_000_000;

   // channel message kinds not in the package
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_POLY     = 4'hA;
   localparam logic [3:0] KIND_CONTROL  = 4'hB;
   localparam logic [3:0] KIND_BEND     = 4'hE;

   // system messages the filter drops
   localparam logic [7:0] ST_SYSEX_START    = 8'hF0;
   localparam logic [7:0] ST_UNDEFINED      = 8'hF9;
   localparam logic [7:0] ST_ACTIVE_SENSING = 8'hFE;

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [7:0]  req_status = 8'h00;
   logic [7:0]  req_data1 = 8'h00;
   logic [7:0]  req_data2 = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_recovered;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit             hold_off_req = 1'b0;
   ring_scoreboard sb;

   midi_event_filter_byte_queue dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_status    (req_status),
      .req_data1     (req_data1),
      .req_data2     (req_data2),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_recovered (rsp_recovered),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_out_valid, rsp_out_byte, rsp_recovered);
   end

   // receiver: stall patterns in segments, long hold-off on request
   initial begin : receiver
      int mode;
      int seg;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(8, 80);
         repeat (seg) begin
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = 1'($urandom_range(0, 1));
               2: rsp_ready = ~rsp_ready;
               default: rsp_ready = ($urandom_range(0, 7) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // one request transaction, held until accepted
   task send_item(input logic func, input logic [7:0] st, input logic [7:0] d1,
                  input logic [7:0] d2);
      req_func   = func;
      req_status = st;
      req_data1  = d1;
      req_data2  = d2;
      req_valid  = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(func, st, d1, d2);
      @(negedge clock);
   endtask

   task sender_gap(input int n);
      req_valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // let every outstanding response come back
   task wait_for_results();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // apb setup and access cycles
   task csr_access(input logic write, input logic sel, input logic [31:0] wdata,
                   output logic [31:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = {sel, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task apply_config(input logic [3:0] divide, input logic [4:0] limit);
      logic [31:0] rd;
      csr_access(1'b1, CSR_CLOCK_DIVIDE, 32'(divide), rd);
      csr_access(1'b1, CSR_CHANNEL_LIMIT, 32'(limit), rd);
      csr_access(1'b0, CSR_CLOCK_DIVIDE, 32'd0, rd);
      if (rd[3:0] !== divide)
         sb.report_mismatch($sformatf("clock_divide reads %h, want %h", rd[3:0], divide));
      csr_access(1'b0, CSR_CHANNEL_LIMIT, 32'd0, rd);
      if (rd[4:0] !== limit)
         sb.report_mismatch($sformatf("channel_limit reads %h, want %h", rd[4:0], limit));
      sb.set_config(divide, limit);
   endtask

   // random event, mostly statuses the filter acts on
   task pick_event(output logic [7:0] st, output logic [7:0] d1, output logic [7:0] d2);
      int r;
      int kind;
      int chan;
      int top;
      r       = $urandom_range(0, 99);
      d1      = 8'($urandom);
      d2      = 8'($urandom);
      top     = (sb.channel_limit > 16) ? 16 : int'(sb.channel_limit);
      if (r < 60) begin
         kind = $urandom_range(int'(KIND_NOTE_OFF), int'(KIND_BEND));
         if (top != 0 && $urandom_range(0, 3) != 0)
            chan = $urandom_range(0, top - 1);
         else
            chan = $urandom_range(0, 15);
         st      = {4'(kind), 4'(chan)};
      end else if (r < 75) begin
         st = ST_TIMING_CLOCK;
      end else if (r < 83) begin
         st = $urandom_range(0, 1) ? ST_START : ST_CONTINUE;
      end else if (r < 90) begin
         st = $urandom_range(0, 1) ? ST_STOP : ST_SYS_RESET;
      end else begin
         st      = 8'($urandom);
      end
   endtask

   // random traffic in fill, drain and mixed segments, sent in bursts
   task run_phase(input int budget);
      int               done;
      int               seg_left;
      int               burst_left;
      int               drain_pct;
      int               gap;
      segment_kind_type kind;
      logic             func;
      logic [7:0]       st;
      logic [7:0]       d1;
      logic [7:0]       d2;
      done       = 0;
      seg_left   = 0;
      burst_left = 0;
      drain_pct  = 0;
      while (done < budget) begin
         if (seg_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: kind = SEG_FILL;
               4, 5:       kind = SEG_DRAIN;
               default:    kind = SEG_MIXED;
            endcase
            case (kind)
               SEG_FILL: begin
                  seg_left  = $urandom_range(100, 200);
                  drain_pct = 3;
               end
               SEG_DRAIN: begin
                  seg_left  = $urandom_range(40, 120);
                  drain_pct = 85;
               end
               default: begin
                  seg_left  = $urandom_range(20, 60);
                  drain_pct = 45;
               end
            endcase
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) sender_gap(gap);
            burst_left = $urandom_range(1, 24);
         end
         if ($urandom_range(0, 99) < drain_pct) begin
            func    = FUNC_DRAIN;
            st      = 8'($urandom);
            d1      = 8'($urandom);
            d2      = 8'($urandom);
         end else begin
            func = FUNC_EVENT;
            pick_event(st, d1, d2);
         end
         send_item(func, st, d1, d2);
         done++;
         seg_left--;
         burst_left--;
      end
   endtask

   // main sequence
   initial begin : stimulus
      int         ph;
      logic [3:0] divide;
      logic [4:0] limit;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, every kind of status, empty drain
      send_item(FUNC_DRAIN, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_EVENT, {KIND_NOTE_ON, 4'd0}, 8'h00, 8'hFF);
      send_item(FUNC_EVENT, {KIND_PROGRAM, 4'd3}, 8'h7F, 8'hAA);
      send_item(FUNC_EVENT, {KIND_PRESSURE, 4'd2}, 8'hFF, 8'h00);
      send_item(FUNC_EVENT, ST_CHAN_FIRST, 8'h55, 8'hAA);
      send_item(FUNC_EVENT, {KIND_POLY, 4'd1}, 8'hFF, 8'hFF);
      send_item(FUNC_EVENT, {KIND_BEND, 4'd1}, 8'h00, 8'h7F);
      // channels at and above the limit
      send_item(FUNC_EVENT, {KIND_CONTROL, 4'd4}, 8'h12, 8'h34);
      send_item(FUNC_EVENT, ST_CHAN_LAST, 8'hFF, 8'hFF);
      // divided timing clock: one byte every sixth
      repeat (6) send_item(FUNC_EVENT, ST_TIMING_CLOCK, 8'h00, 8'h00);
      send_item(FUNC_EVENT, ST_START, 8'h00, 8'h00);
      send_item(FUNC_EVENT, ST_CONTINUE, 8'h00, 8'h00);
      send_item(FUNC_EVENT, ST_STOP, 8'h00, 8'h00);
      send_item(FUNC_EVENT, ST_SYS_RESET, 8'h00, 8'h00);
      // dropped statuses
      send_item(FUNC_EVENT, 8'h00, 8'hFF, 8'hFF);
      send_item(FUNC_EVENT, ST_SYSEX_START, 8'h00, 8'h00);
      send_item(FUNC_EVENT, ST_UNDEFINED, 8'h00, 8'h00);
      send_item(FUNC_EVENT, ST_ACTIVE_SENSING, 8'h00, 8'h00);
      repeat (3) send_item(FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      wait_for_results();

      // random phases over a sweep of register settings
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin divide = 4'd0;  limit = 5'd16; end
            1: begin divide = 4'd15; limit = 5'd0;  end
            2: begin divide = 4'd1;  limit = 5'd31; end
            3: begin divide = 4'd15; limit = 5'd1;  end
            4: begin divide = DIVIDE_RESET; limit = LIMIT_RESET; end
            default: begin
               divide = 4'($urandom_range(0, 15));
               limit  = 5'($urandom_range(0, 31));
            end
         endcase
         apply_config(divide, limit);
         if (ph == 0 || ph == 4) hold_off_req = 1'b1;
         run_phase(RANDOM_ITEMS / PHASES);
         wait_for_results();
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS midi_event_filter_byte_queue");
      else
         $display("FAIL midi_event_filter_byte_queue");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(LIMIT_NS);
      $display("FAIL midi_event_filter_byte_queue");
      $finish;
   end

endmodule

FILE: files.f
hdl/mefbq_pkg.sv
hdl/mefbq_ring.sv
hdl/midi_event_filter_byte_queue.sv
verif/mefbq_scoreboard.sv
verif/tb.sv
